@@ src/rsr_pkg.sv @@
// Shared types, constants and sequence helpers for the reliable sequence reorder block.
// No dependencies; used by the queue, the engine, the top level and the testbench.
package rsr_pkg;

  localparam int SEQ_W  = 16;
  localparam int TAG_W  = 32;
  localparam int LEN_W  = 11;
  localparam int STAT_W = 3;
  localparam int DATA_W = 64;
  localparam int PAD_W  = DATA_W - SEQ_W - TAG_W - LEN_W;

  // Half of the sequence space: the boundary between behind and ahead
  localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;

  typedef enum logic [STAT_W-1:0] {
    ST_DELIVERED = 3'd0,
    ST_STALE     = 3'd1,
    ST_HELD      = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic {
    ENG_IDLE,
    ENG_DRAIN
  } eng_state_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic [TAG_W-1:0] tag;
    logic [SEQ_W-1:0] seq;
  } item_t;

  typedef struct packed {
    status_t status;
    item_t   item;
    logic    last;
  } result_t;

  // Next sequence, skipping zero on wrap
  function automatic logic [SEQ_W-1:0] seq_next(input logic [SEQ_W-1:0] s);
    logic [SEQ_W-1:0] n;
    n = s + SEQ_W'(1);
    return (n == '0) ? SEQ_W'(1) : n;
  endfunction

  // True when a is ahead of b, the short way round the wrap
  function automatic logic seq_ahead(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
    logic [SEQ_W-1:0] d;
    d = a - b;
    return (d != '0) && ((d < SEQ_HALF) || ((d == SEQ_HALF) && (a > b)));
  endfunction

endpackage

@@ src/rsr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/rsr_queue.sv @@
// Front queue: two-entry request FIFO between the input channel and the engine.
// Depends on rsr_pkg for the item type.
module rsr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rsr_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output rsr_pkg::item_t out_item
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  rsr_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign in_ready  = (cnt_r != CNT_W'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

@@ src/rsr_engine.sv @@
// Back engine: classifies each queued request against the slot store, parks early
// ones and drains held successors one per cycle while the output accepts. Depends on rsr_pkg and rsr_ram.
module rsr_engine #(
  parameter int HOLD_SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  output logic            q_ready,
  input  rsr_pkg::item_t  q_item,
  output logic            res_valid,
  input  logic            res_ready,
  output rsr_pkg::result_t res
);

  localparam int IDX_W = (HOLD_SLOTS > 1) ? $clog2(HOLD_SLOTS) : 1;
  localparam int RAM_W = rsr_pkg::TAG_W + rsr_pkg::LEN_W;

  rsr_pkg::eng_state_t      state_r, state_nxt;
  logic [rsr_pkg::SEQ_W-1:0] exp_r, exp_nxt;
  logic [HOLD_SLOTS-1:0]    valid_r, valid_nxt;
  logic [rsr_pkg::SEQ_W-1:0] slot_seq_r [HOLD_SLOTS];
  logic [IDX_W-1:0]         hit_r, hit_nxt;
  logic                     res_valid_r, res_valid_nxt;
  rsr_pkg::result_t         res_r, res_nxt;

  logic [rsr_pkg::SEQ_W-1:0] exp_next;
  logic [rsr_pkg::SEQ_W-1:0] key;
  logic [HOLD_SLOTS-1:0]    match;
  logic                     any_match;
  logic [IDX_W-1:0]         match_idx;
  logic [IDX_W-1:0]         free_idx;
  logic                     full;
  logic                     stale, in_order;
  logic                     out_load, take;
  logic                     hold_wr;
  logic                     rd_en;
  logic [RAM_W-1:0]         rd_data;

  // Classify the head request
  assign exp_next = rsr_pkg::seq_next(exp_r);
  assign stale    = rsr_pkg::seq_ahead(exp_r, q_item.seq);
  assign in_order = (q_item.seq == exp_r);
  assign out_load = !res_valid_r || res_ready;
  assign q_ready  = (state_r == rsr_pkg::ENG_IDLE) && out_load;
  assign take     = q_valid && q_ready;

  // Search key: the request itself for a duplicate check, else the next expected
  assign key = ((state_r == rsr_pkg::ENG_IDLE) && !in_order) ? q_item.seq : exp_next;

  // Compare every slot against the key
  always_comb begin
    for (int i = 0; i < HOLD_SLOTS; i++) begin
      match[i] = valid_r[i] && (slot_seq_r[i] == key);
    end
  end

  assign any_match = |match;
  assign full      = &valid_r;

  // Pick the lowest matching slot and the lowest free slot
  always_comb begin
    match_idx = '0;
    free_idx  = '0;
    for (int i = HOLD_SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        match_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsr_pkg::ENG_IDLE: begin
        if (take && !stale && in_order && any_match) begin
          state_nxt = rsr_pkg::ENG_DRAIN;
        end
      end
      rsr_pkg::ENG_DRAIN: begin
        if (out_load && !any_match) begin
          state_nxt = rsr_pkg::ENG_IDLE;
        end
      end
      default: state_nxt = rsr_pkg::ENG_IDLE;
    endcase
  end

  // Results, slot updates and store accesses
  always_comb begin
    exp_nxt       = exp_r;
    valid_nxt     = valid_r;
    hit_nxt       = hit_r;
    res_nxt       = res_r;
    res_valid_nxt = res_valid_r && !res_ready;
    hold_wr       = 1'b0;
    rd_en         = 1'b0;
    case (state_r)
      rsr_pkg::ENG_IDLE: begin
        if (take) begin
          res_valid_nxt = 1'b1;
          res_nxt.item  = q_item;
          res_nxt.last  = 1'b1;
          if (stale) begin
            res_nxt.status = rsr_pkg::ST_STALE;
          end else if (!in_order) begin
            if (any_match) begin
              res_nxt.status = rsr_pkg::ST_DUPLICATE;
            end else if (full) begin
              res_nxt.status = rsr_pkg::ST_FULL;
            end else begin
              res_nxt.status      = rsr_pkg::ST_HELD;
              hold_wr             = 1'b1;
              valid_nxt[free_idx] = 1'b1;
            end
          end else begin
            res_nxt.status = rsr_pkg::ST_DELIVERED;
            res_nxt.last   = !any_match;
            exp_nxt        = exp_next;
            rd_en          = any_match;
            hit_nxt        = match_idx;
          end
        end
      end
      rsr_pkg::ENG_DRAIN: begin
        if (out_load) begin
          res_valid_nxt    = 1'b1;
          res_nxt.status   = rsr_pkg::ST_DELIVERED;
          res_nxt.item.seq = exp_r;
          res_nxt.item.tag = rd_data[rsr_pkg::TAG_W-1:0];
          res_nxt.item.length = rd_data[RAM_W-1:rsr_pkg::TAG_W];
          res_nxt.last     = !any_match;
          valid_nxt[hit_r] = 1'b0;
          exp_nxt          = exp_next;
          rd_en            = any_match;
          hit_nxt          = match_idx;
        end
      end
      default: begin
        res_valid_nxt = res_valid_r && !res_ready;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsr_pkg::ENG_IDLE;
      exp_r       <= rsr_pkg::SEQ_W'(1);
      valid_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      valid_r     <= valid_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    hit_r <= hit_nxt;
    if (hold_wr) begin
      slot_seq_r[free_idx] <= q_item.seq;
    end
  end

  // Tag and length of parked requests
  rsr_ram #(
    .WIDTH (RAM_W),
    .DEPTH (HOLD_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (hold_wr),
    .wr_addr (free_idx),
    .wr_data ({q_item.length, q_item.tag}),
    .rd_en   (rd_en),
    .rd_addr (match_idx),
    .rd_data (rd_data)
  );

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

@@ src/reliable_seq_reorder.sv @@
// Reliable sequence reorder buffer: in-order release of packet descriptors.
// Path from input accept to the first result: front queue, then result register.
// Throughput: one input per cycle for single-result inputs while the output accepts; an in-order
// input that releases held packets holds off new inputs until the engine has drained them.
// Reset: synchronous active-low; expected sequence set to 1, all slots freed, queues emptied.
module reliable_seq_reorder #(
  parameter int HOLD_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // sequence[15:0], tag[47:16], length[58:48], zero[63:59]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // sequence[15:0], tag[47:16], length[58:48], zero[63:59]
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast
);

  rsr_pkg::item_t   in_item;
  rsr_pkg::item_t   q_item;
  logic             q_valid, q_ready;
  rsr_pkg::result_t res;

  // Unpack the incoming request
  assign in_item.seq    = in_tdata[rsr_pkg::SEQ_W-1:0];
  assign in_item.tag    = in_tdata[rsr_pkg::SEQ_W+rsr_pkg::TAG_W-1:rsr_pkg::SEQ_W];
  assign in_item.length = in_tdata[rsr_pkg::DATA_W-rsr_pkg::PAD_W-1:rsr_pkg::SEQ_W+rsr_pkg::TAG_W];

  rsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_item   (in_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  rsr_engine #(
    .HOLD_SLOTS (HOLD_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // Pack the result
  assign out_tdata = {{rsr_pkg::PAD_W{1'b0}}, res.item.length, res.item.tag, res.item.seq};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

@@ sim/tb.sv @@
// Testbench for reliable_seq_reorder: streams packet descriptors and checks every release.
// Depends on rsr_pkg (item and result types, status codes) and the reorder RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS   = 16;
  localparam int HALF_RANGE  = 32768;
  localparam int MAX_LEN     = 1188;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 40;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  // Shadow of the reorder state
  logic [15:0]     exp_seq;
  logic            held_valid [NUM_SLOTS];
  rsr_pkg::item_t  held_item  [NUM_SLOTS];

  rsr_pkg::result_t due_results [$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  bit      idle_on        = 1'b1;
  int      hold_off       = 0;
  int      stall_left     = 0;

  reliable_seq_reorder #(
    .HOLD_SLOTS(NUM_SLOTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // a is ahead of b, judged the short way round the 16-bit wrap
  function automatic bit seq_is_ahead(input logic [15:0] a, input logic [15:0] b);
    int unsigned ai;
    int unsigned bi;
    ai = a;
    bi = b;
    if (ai > bi) return (ai - bi) <= HALF_RANGE;
    if (ai < bi) return (bi - ai) > HALF_RANGE;
    return 1'b0;
  endfunction

  // Advance a sequence, skipping zero
  function automatic logic [15:0] bump_seq(input logic [15:0] s);
    logic [15:0] n;
    n = s + 16'd1;
    return (n == 16'd0) ? 16'd1 : n;
  endfunction

  function automatic rsr_pkg::result_t make_result(input rsr_pkg::status_t st,
                                                   input rsr_pkg::item_t it);
    rsr_pkg::result_t r;
    r.status = st;
    r.item   = it;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic logic [10:0] rand_len();
    return 11'($urandom_range(1, MAX_LEN));
  endfunction

  // Work out the releases caused by one accepted descriptor
  function automatic void reorder_arrival(input rsr_pkg::item_t it);
    rsr_pkg::result_t batch [NUM_SLOTS + 1];
    int      nb;
    int      hit;
    int      free_idx;
    bit      dup;
    nb       = 0;
    dup      = 1'b0;
    free_idx = -1;
    if (seq_is_ahead(exp_seq, it.seq)) begin
      batch[nb] = make_result(rsr_pkg::ST_STALE, it);
      nb++;
    end else if (it.seq != exp_seq) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (held_valid[i] && held_item[i].seq == it.seq) dup = 1'b1;
      end
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
        if (!held_valid[i]) free_idx = i;
      end
      if (dup) begin
        batch[nb] = make_result(rsr_pkg::ST_DUPLICATE, it);
      end else if (free_idx < 0) begin
        batch[nb] = make_result(rsr_pkg::ST_FULL, it);
      end else begin
        held_valid[free_idx] = 1'b1;
        held_item[free_idx]  = it;
        batch[nb] = make_result(rsr_pkg::ST_HELD, it);
      end
      nb++;
    end else begin
      batch[nb] = make_result(rsr_pkg::ST_DELIVERED, it);
      nb++;
      exp_seq = bump_seq(exp_seq);
      // Drain held successors one by one
      while (1) begin
        hit = -1;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
          if (held_valid[i] && held_item[i].seq == exp_seq) hit = i;
        end
        if (hit < 0) break;
        batch[nb] = make_result(rsr_pkg::ST_DELIVERED, held_item[hit]);
        nb++;
        held_valid[hit] = 1'b0;
        exp_seq = bump_seq(exp_seq);
      end
    end
    batch[nb - 1].last = 1'b1;
    for (int i = 0; i < nb; i++) due_results.insert(due_results.size(), batch[i]);
  endfunction

  // Offer one descriptor and hold it until accepted
  task automatic send_item(input logic [15:0] seq, input logic [31:0] tag,
                           input logic [10:0] len);
    rsr_pkg::item_t it;
    it.seq    = seq;
    it.tag    = tag;
    it.length = len;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(64 - $bits(rsr_pkg::item_t)){1'b0}}, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    reorder_arrival(it);
  endtask

  // Check each result against the oldest pending release and pace out_tready
  initial begin
    rsr_pkg::result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result with nothing pending: out_sequence %0d out_status %0d",
                 out_tdata[15:0], out_tuser);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          if (out_tuser !== want.status) begin
            $error("out_status expected %0d actual %0d", want.status, out_tuser);
            mismatch_count++;
          end
          if (out_tdata[15:0] !== want.item.seq) begin
            $error("out_sequence expected %0d actual %0d", want.item.seq, out_tdata[15:0]);
            mismatch_count++;
          end
          if (out_tdata[47:16] !== want.item.tag) begin
            $error("out_tag expected %h actual %h", want.item.tag, out_tdata[47:16]);
            mismatch_count++;
          end
          if (out_tdata[58:48] !== want.item.length) begin
            $error("out_length expected %0d actual %0d", want.item.length,
                   out_tdata[58:48]);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last expected %0d actual %0d", want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
      // Long hold-off first, then random stall bursts
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // One stretch of traffic: mostly a shuffled in-order window, some noise
  task automatic random_burst(output int sent);
    logic [15:0] win [8];
    logic [15:0] base;
    logic [15:0] tmp;
    int          n;
    int          pick;
    sent = 0;
    base = exp_seq;
    case ($urandom_range(0, 9))
      0: begin
        send_item(base - 16'($urandom_range(1, 40)), $urandom, rand_len());
        sent = 1;
      end
      1: begin
        send_item(base + 16'($urandom_range(8, 30)), $urandom, rand_len());
        sent = 1;
      end
      2: begin
        send_item(base + 16'($urandom_range(HALF_RANGE + 1, 65535)), $urandom, rand_len());
        sent = 1;
      end
      default: begin
        n = $urandom_range(1, 8);
        for (int j = 0; j < n; j++) win[j] = base + 16'(j);
        for (int j = n - 1; j > 0; j--) begin
          pick      = $urandom_range(0, j);
          tmp       = win[j];
          win[j]    = win[pick];
          win[pick] = tmp;
        end
        for (int j = 0; j < n; j++) begin
          send_item(win[j], $urandom, rand_len());
          sent++;
          if ($urandom_range(0, 5) == 0) begin
            send_item(win[$urandom_range(0, j)], $urandom, rand_len());
            sent++;
          end
        end
      end
    endcase
  endtask

  task automatic test_in_order_start();
    send_item(16'd1, 32'h0000_0000, 11'd1);
  endtask

  // Sequence zero and a repeat of a delivered one are both behind
  task automatic test_stale();
    send_item(16'd0, 32'h1234_5678, 11'd600);
    send_item(16'd1, 32'hFFFF_FFFF, 11'(MAX_LEN));
  endtask

  task automatic test_hold_release();
    logic [15:0] e;
    e = exp_seq;
    send_item(e + 16'd2, $urandom, rand_len());
    send_item(e + 16'd1, $urandom, rand_len());
    send_item(e + 16'd2, $urandom, rand_len());
    send_item(e, $urandom, rand_len());
  endtask

  // Fill every slot, overflow, repeat a held one, then release the lot
  task automatic test_store_full();
    logic [15:0] e;
    e = exp_seq;
    for (int k = 1; k <= NUM_SLOTS; k++) send_item(e + 16'(k), $urandom, rand_len());
    send_item(e + 16'(NUM_SLOTS + 1), $urandom, rand_len());
    send_item(e + 16'd1, $urandom, rand_len());
    send_item(e, $urandom, rand_len());
  endtask

  // Exactly half a range ahead is still early; one more is behind
  task automatic test_window_edge();
    logic [15:0] e;
    e = exp_seq;
    send_item(e + 16'(HALF_RANGE), $urandom, 11'd1024);
    send_item(e + 16'(HALF_RANGE + 1), $urandom, 11'd1023);
  endtask

  task automatic test_random_traffic(input int n);
    int total;
    int got;
    total = 0;
    while (total < n) begin
      random_burst(got);
      total += got;
    end
  endtask

  // Hold the output off long enough that the block backs up its input
  task automatic test_output_stall();
    int total;
    int got;
    total    = 0;
    hold_off = 500;
    while (total < 60) begin
      random_burst(got);
      total += got;
    end
  endtask

  // Park a wide shuffled window in reverse, then release it with its head
  task automatic test_window_reorder();
    logic [15:0] win [14];
    logic [15:0] tmp;
    int          pick;
    win[0] = exp_seq;
    for (int j = 1; j < 14; j++) win[j] = bump_seq(win[j-1]);
    for (int j = 13; j > 1; j--) begin
      pick      = $urandom_range(1, j);
      tmp       = win[j];
      win[j]    = win[pick];
      win[pick] = tmp;
    end
    for (int j = 13; j >= 0; j--) send_item(win[j], $urandom, rand_len());
    // Zero and the top of the range both lie behind here
    send_item(16'd0, $urandom, rand_len());
    send_item(16'd65535, $urandom, rand_len());
  endtask

  initial begin
    exp_seq = 16'd1;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      held_valid[i] = 1'b0;
      held_item[i]  = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_in_order_start();
    test_stale();
    test_hold_release();
    test_store_full();
    test_window_edge();
    test_random_traffic(280);
    test_output_stall();
    test_window_reorder();
    // Close with steady traffic, no idling on either side
    idle_on = 1'b0;
    test_random_traffic(80);

    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
